// ----- rtl/sbas_pkg.sv -----
// Shared types and constants for the six-axis bias averaging block.
`default_nettype none

package sbas_pkg;

  // Number of sensor axes: three forces and three torques.
  localparam int AXES = 6;

  // Width of one Q16.16 axis value.
  localparam int AXIS_W = 32;

  // Width of the sample count register and of the sample counter.
  localparam int CNT_W = 13;

  // Largest value the count register can hold.
  localparam int CNT_MAX = (2 ** CNT_W) - 1;

  // Count register value after reset.
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(100);

  // Saturation bounds of a corrected axis value.
  localparam logic [AXIS_W-1:0] SAT_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
  localparam logic [AXIS_W-1:0] SAT_MIN = {1'b1, {(AXIS_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DABS,
    S_DSTEP,
    S_DFIX,
    S_COR,
    S_DONE
  } sbas_state_t;

endpackage

`default_nettype wire

// ----- rtl/six_axis_bias_average_and_subtract.sv -----
// Six-axis force/torque sensor tare: bias averaging and bias subtraction.
// The input channel carries one sample of six Q16.16 axes in in_tdata and a
// command flag in in_tuser; a set flag starts a new bias measurement. Every
// input item yields exactly one result item on the output channel: the raw
// sample while the bias is being measured, the sample minus the bias
// (saturated to 32 bits) otherwise, and all zeros for a start command.
// out_tuser tells whether bias measurement is still running after the item.
// The count of averaged samples is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Zero acts as one and large values are capped.
// All arithmetic goes through one shared adder, one axis per cycle, and no
// new item is accepted until the last one has left the sequencer; a start
// command goes from idle straight to the output stage. The sample that
// closes a measurement also runs a restoring divide for each axis on the
// same adder, one quotient bit per cycle, before it is corrected.
// in_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next item is
// accepted and processed; if the receiver still stalls when that item is
// done, the sequencer holds it until the register frees up.
// Reset clears the bias to zero, leaves bias mode, and sets the count to 100.
`default_nettype none

module six_axis_bias_average_and_subtract
  import sbas_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // in_tdata, lowest bit up: force_x, force_y, force_z, torque_x, torque_y, torque_z.
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [AXES*AXIS_W-1:0]   in_tdata,
  // in_tuser: op (1 starts a bias measurement, 0 is a sensor sample).
  input  wire logic [0:0]               in_tuser,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // out_tdata, lowest bit up: out_force_x, out_force_y, out_force_z,
  // out_torque_x, out_torque_y, out_torque_z.
  output logic      [AXES*AXIS_W-1:0]   out_tdata,
  // out_tuser: measuring.
  output logic      [0:0]               out_tuser,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CNT_W-1:0]         cfg_wr_data
);

  // The count register cannot exceed its own range, so the cap is the smaller bound.
  localparam int CAP = (MAX_SAMPLES < CNT_MAX) ? MAX_SAMPLES : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAP);
  // A sum of CAP samples of 32 bits fits in this many signed bits.
  localparam int SUM_W  = AXIS_W + $clog2(CAP);
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
  localparam logic [2:0] LAST_AXIS = 3'(AXES - 1);

  sbas_state_t state_r, state_nxt;

  logic [2:0]          axis_r;
  logic [SUM_W-1:0]    sum_r [AXES];
  logic [AXIS_W-1:0]   smp_r [AXES];
  logic [CNT_W-1:0]    taken_r;
  logic                bias_mode_r;
  logic                meas_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic                neg_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    cnt_cfg_r;
  logic                out_valid_r;
  logic [AXES*AXIS_W-1:0] out_data_r;
  logic                out_meas_r;

  logic [CNT_W-1:0]    n_eff;
  logic [CNT_W:0]      trial;
  logic [SUM_W:0]      alu_a, alu_b, alu_res;
  logic                alu_sub;
  logic [AXIS_W-1:0]   alu_sat;
  logic                in_acc;
  logic                out_load;
  logic [SUM_W-1:0]    cur_sum;
  logic [AXIS_W-1:0]   cur_smp;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_meas_r;

  // Effective averaging count: zero acts as one, large values are capped.
  always_comb begin
    if (cnt_cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (cnt_cfg_r > CAP_W) begin
      n_eff = CAP_W;
    end else begin
      n_eff = cnt_cfg_r;
    end
  end

  assign cur_sum = sum_r[axis_r];
  assign cur_smp = smp_r[axis_r];
  // Partial remainder shifted left with the next dividend bit brought in.
  assign trial   = {rem_r, quo_r[SUM_W-1]};

  sbas_alu #(
    .W (SUM_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .sat (alu_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and operand selection for the shared adder.
  always_comb begin
    state_nxt = state_r;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            state_nxt = S_DONE;
          end else if (bias_mode_r && (taken_r < n_eff)) begin
            state_nxt = S_ACC;
          end else if (bias_mode_r) begin
            state_nxt = S_DABS;
          end else begin
            state_nxt = S_COR;
          end
        end
      end
      S_ACC: begin
        alu_a = {cur_sum[SUM_W-1], cur_sum};
        alu_b = {{(SUM_W+1-AXIS_W){cur_smp[AXIS_W-1]}}, cur_smp};
        if (axis_r == LAST_AXIS) begin
          state_nxt = S_DONE;
        end
      end
      S_DABS: begin
        alu_b     = {cur_sum[SUM_W-1], cur_sum};
        alu_sub   = cur_sum[SUM_W-1];
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        alu_a   = {{(SUM_W-CNT_W){1'b0}}, trial};
        alu_b   = {{(SUM_W+1-CNT_W){1'b0}}, n_eff};
        alu_sub = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DFIX;
        end
      end
      S_DFIX: begin
        alu_b   = {1'b0, quo_r};
        alu_sub = neg_r;
        if (axis_r == LAST_AXIS) begin
          state_nxt = S_COR;
        end else begin
          state_nxt = S_DABS;
        end
      end
      S_COR: begin
        alu_a   = {{(SUM_W+1-AXIS_W){cur_smp[AXIS_W-1]}}, cur_smp};
        alu_b   = {cur_sum[SUM_W-1], cur_sum};
        alu_sub = 1'b1;
        if (axis_r == LAST_AXIS) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r   <= CNT_RESET;
      taken_r     <= '0;
      bias_mode_r <= 1'b0;
      meas_r      <= 1'b0;
      axis_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < AXES; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cnt_cfg_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          axis_r <= '0;
          if (in_acc) begin
            if (in_tuser[0]) begin
              for (int k = 0; k < AXES; k++) begin
                sum_r[k] <= '0;
              end
              taken_r     <= '0;
              bias_mode_r <= 1'b1;
              meas_r      <= 1'b1;
            end else if (bias_mode_r && (taken_r < n_eff)) begin
              taken_r <= taken_r + CNT_W'(1);
              meas_r  <= 1'b1;
            end else begin
              bias_mode_r <= 1'b0;
              meas_r      <= 1'b0;
            end
          end
        end
        S_ACC: begin
          sum_r[axis_r] <= alu_res[SUM_W-1:0];
          axis_r        <= axis_r + 3'd1;
        end
        S_DABS: begin
          step_r <= '0;
        end
        S_DSTEP: begin
          step_r <= step_r + STEP_W'(1);
        end
        S_DFIX: begin
          sum_r[axis_r] <= alu_res[SUM_W-1:0];
          if (axis_r == LAST_AXIS) begin
            axis_r <= '0;
          end else begin
            axis_r <= axis_r + 3'd1;
          end
        end
        S_COR: begin
          axis_r <= axis_r + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Sample, divider and output payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int k = 0; k < AXES; k++) begin
            smp_r[k] <= in_tuser[0] ? '0 : in_tdata[k*AXIS_W +: AXIS_W];
          end
        end
      end
      S_DABS: begin
        quo_r <= alu_res[SUM_W-1:0];
        neg_r <= cur_sum[SUM_W-1];
        rem_r <= '0;
      end
      S_DSTEP: begin
        if (!alu_res[SUM_W]) begin
          rem_r <= alu_res[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[CNT_W-1:0];
          quo_r <= {quo_r[SUM_W-2:0], 1'b0};
        end
      end
      S_COR: begin
        smp_r[axis_r] <= alu_sat;
      end
      S_DONE: begin
        if (out_load) begin
          for (int k = 0; k < AXES; k++) begin
            out_data_r[k*AXIS_W +: AXIS_W] <= smp_r[k];
          end
          out_meas_r <= meas_r;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // The sample counter never passes the largest count that can be in effect.
  a_taken_cap: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= CAP_W)
    else $error("sample counter exceeds the count cap");

  // A start command leaves bias mode set with an empty sample count.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> (bias_mode_r && (taken_r == '0)))
    else $error("start command did not reset the measurement");

  // The divider's partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP) |-> (rem_r < n_eff))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/sbas_alu.sv -----
// Shared adder/subtractor with signed 32-bit saturation of its result.
`default_nettype none

module sbas_alu
  import sbas_pkg::*;
#(
  parameter int W = 44
) (
  input  wire logic [W:0]        a,
  input  wire logic [W:0]        b,
  input  wire logic              sub,
  output logic      [W:0]        res,
  output logic      [AXIS_W-1:0] sat
);

  logic [W:AXIS_W-1] hi;

  // Subtraction is a plus the inverted b plus one.
  assign res = a + (b ^ {(W+1){sub}}) + {{W{1'b0}}, sub};
  assign hi  = res[W:AXIS_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat = res[AXIS_W-1:0];
    end else if (res[W]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

endmodule

`default_nettype wire
